// ----- rtl/assert_macros.svh -----
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("invariant violated");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication violated");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- rtl/utf8sd_pkg.sv -----
// shared types and constants for the utf-8 stream decoder
`default_nettype none

package utf8sd_pkg;

    localparam int CP_W = 21;

    // replacement character for malformed input
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // one decoded byte as it passes from front to back: up to two results
    typedef struct packed {
        logic [CP_W-1:0] cp0;
        logic            bad0;
        logic [CP_W-1:0] cp1;
        logic            bad1;
        logic            dual;
        logic            text_end;
    } byte_entry_t;

endpackage

`default_nettype wire

// ----- rtl/utf8sd_front.sv -----
// front end: accepts text bytes, tracks the pending sequence, builds result entries
`default_nettype none
`include "assert_macros.svh"

module utf8sd_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // [7:0] text_byte
    input  wire logic                    s_tlast,   // text_end
    input  wire logic                    q_full,
    output logic                         q_push,
    output utf8sd_pkg::byte_entry_t      q_entry
);
    import utf8sd_pkg::*;

    typedef enum logic [1:0] {
        KIND_ASCII,
        KIND_LEAD,
        KIND_INVALID
    } byte_kind_t;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      owed_reg, owed_next;

    logic            accept;
    logic [7:0]      b;
    logic            text_end;
    byte_kind_t      kind;
    logic [CP_W-1:0] lead_bits;
    logic [1:0]      lead_owed;
    logic            st_has;
    logic [CP_W-1:0] st_cp;
    logic            st_bad;
    logic [CP_W-1:0] st_partial;
    logic [1:0]      st_owed;
    logic            is_cont;
    logic [CP_W-1:0] shifted;
    logic            has_res;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign text_end = s_tlast;
    assign is_cont  = (b[7:6] == 2'b10);
    assign shifted  = {partial_reg[CP_W-7:0], b[5:0]};

    // classify the byte as a start byte
    always_comb begin
        lead_bits = '0;
        lead_owed = 2'd0;
        priority if (!b[7]) begin
            kind = KIND_ASCII;
        end else if (b[7:5] == 3'b110) begin
            kind      = KIND_LEAD;
            lead_bits = {{(CP_W-5){1'b0}}, b[4:0]};
            lead_owed = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            kind      = KIND_LEAD;
            lead_bits = {{(CP_W-4){1'b0}}, b[3:0]};
            lead_owed = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            kind      = KIND_LEAD;
            lead_bits = {{(CP_W-3){1'b0}}, b[2:0]};
            lead_owed = 2'd3;
        end else begin
            kind = KIND_INVALID;
        end
    end

    // result and next state of a start byte taken with nothing pending
    always_comb begin
        st_has     = 1'b0;
        st_cp      = REPLACEMENT_CP;
        st_bad     = 1'b1;
        st_partial = '0;
        st_owed    = 2'd0;
        unique case (kind)
            KIND_ASCII: begin
                st_has = 1'b1;
                st_cp  = {{(CP_W-8){1'b0}}, b};
                st_bad = 1'b0;
            end
            KIND_LEAD: begin
                // end of text inside a sequence gives a replacement
                st_has = text_end;
                if (!text_end) begin
                    st_partial = lead_bits;
                    st_owed    = lead_owed;
                end
            end
            default: begin
                st_has = 1'b1;
            end
        endcase
    end

    // combine with the pending sequence
    always_comb begin
        has_res          = 1'b0;
        q_entry.cp0      = REPLACEMENT_CP;
        q_entry.bad0     = 1'b1;
        q_entry.cp1      = st_cp;
        q_entry.bad1     = st_bad;
        q_entry.dual     = 1'b0;
        q_entry.text_end = text_end;
        partial_next     = st_partial;
        owed_next        = st_owed;
        priority if (owed_reg == 2'd0) begin
            has_res      = st_has;
            q_entry.cp0  = st_cp;
            q_entry.bad0 = st_bad;
        end else if (is_cont) begin
            if (owed_reg == 2'd1) begin
                has_res      = 1'b1;
                q_entry.cp0  = shifted;
                q_entry.bad0 = 1'b0;
                partial_next = '0;
                owed_next    = 2'd0;
            end else if (text_end) begin
                has_res      = 1'b1;
                partial_next = '0;
                owed_next    = 2'd0;
            end else begin
                partial_next = shifted;
                owed_next    = owed_reg - 2'd1;
            end
        end else begin
            // broken sequence: replacement, then decode the byte afresh
            has_res      = 1'b1;
            q_entry.dual = st_has;
        end
    end

    assign q_push = accept && has_res;

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            owed_reg    <= 2'd0;
        end else if (accept) begin
            partial_reg <= partial_next;
            owed_reg    <= owed_next;
        end
    end

    `ASSERT_NEXT(a_end_clears_state, aclk, aresetn, accept && text_end,
                 owed_reg == 2'd0 && partial_reg == '0)
    `ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, q_push, !q_full)

endmodule

`default_nettype wire

// ----- rtl/utf8sd_queue.sv -----
// short entry queue between the front and back ends
`default_nettype none
`include "assert_macros.svh"

module utf8sd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire utf8sd_pkg::byte_entry_t push_entry,
    input  wire logic                    pop,
    output utf8sd_pkg::byte_entry_t      head_entry,
    output logic                         full,
    output logic                         empty
);
    import utf8sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    byte_entry_t      slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = slots[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ----- rtl/utf8sd_back.sv -----
// back end: splits queue entries into single results and holds the output register
`default_nettype none
`include "assert_macros.svh"

module utf8sd_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_empty,
    input  wire utf8sd_pkg::byte_entry_t q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata,   // [20:0] code_point, zero fill above
    output logic [1:0]                   m_tuser,   // [0] malformed, [1] run_last
    output logic                         m_tlast    // final_point
);
    import utf8sd_pkg::*;

    logic            valid_reg;
    logic            second_reg;
    logic [CP_W-1:0] cp_reg;
    logic            bad_reg;
    logic            run_last_reg;
    logic            final_reg;
    logic            out_free;

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = out_free && !q_empty && (second_reg || !q_head.dual);

    // output register and second-result tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= !q_empty;
            if (!q_empty) begin
                if (second_reg) begin
                    cp_reg       <= q_head.cp1;
                    bad_reg      <= q_head.bad1;
                    run_last_reg <= 1'b1;
                    final_reg    <= q_head.text_end;
                    second_reg   <= 1'b0;
                end else begin
                    cp_reg       <= q_head.cp0;
                    bad_reg      <= q_head.bad0;
                    run_last_reg <= !q_head.dual;
                    final_reg    <= q_head.text_end && !q_head.dual;
                    second_reg   <= q_head.dual;
                end
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(24-CP_W){1'b0}}, cp_reg};
    assign m_tuser  = {run_last_reg, bad_reg};
    assign m_tlast  = final_reg;

    `ASSERT_ALWAYS(a_second_has_entry, aclk, aresetn, !second_reg || !q_empty)
    `ASSERT_IMPLIES(a_final_is_run_last, aclk, aresetn, valid_reg && final_reg, run_last_reg)

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder.sv -----
// utf8_stream_decoder: one text byte in per cycle while s_tready is high, decoded code points out.
// Each result passes through the entry queue and then the output register to the master side.
// Throughput: one byte per cycle; a byte that breaks a sequence and yields two
// results holds the output register for each result in turn, and the entry queue
// (QUEUE_DEPTH entries) absorbs such bursts before s_tready drops.
// Reset (aresetn low, synchronous) clears the pending sequence, queue and output valid.
`default_nettype none

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // text_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, zero fill above
    output logic [1:0]       m_tuser,   // [0] malformed, [1] run_last
    output logic             m_tlast    // final_point
);
    import utf8sd_pkg::*;

    byte_entry_t push_entry;
    byte_entry_t head_entry;
    logic        q_push, q_pop, q_full, q_empty;

    // byte intake and classification
    utf8sd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // decoupling queue
    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // result delivery
    utf8sd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/utf8_stream_decoder_test.sv -----
// self-checking testbench for the utf-8 stream decoder
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

    import utf8sd_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 1200;
    localparam int PAUSE_AT       = 700;
    localparam int HOLD_AT_POINT  = 400;
    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    // one text byte waiting to be sent; hold waits for all results first
    typedef struct {
        logic [7:0] text_byte;
        logic       text_end;
        logic       hold;
    } text_item_t;

    // one decoded code point as it should leave the block
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic            run_last;
        logic            final_point;
    } point_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    text_item_t  text_bytes[$];
    point_t      expected_points[$];
    point_t      byte_points[$];
    int          directed_count;
    int          error_count = 0;

    // decoder state mirrored by the predictor
    logic [CP_W-1:0] held_point = '0;
    logic [1:0]      owed_count = '0;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // at most two results per byte
    task automatic emit_point(input logic [CP_W-1:0] cp, input logic bad);
        point_t p;
        p.code_point  = cp;
        p.malformed   = bad;
        p.run_last    = 1'b0;
        p.final_point = 1'b0;
        if (byte_points.size() < 2) byte_points = {byte_points, p};
    endtask

    task automatic drop_sequence();
        held_point = '0;
        owed_count = '0;
    endtask

    // byte seen with nothing owed
    task automatic take_lead_byte(input logic [7:0] b, input logic end_flag);
        casez (b)
            8'b0???????: begin
                emit_point({13'd0, b}, 1'b0);
            end
            8'b110?????: begin
                held_point = {16'd0, b[4:0]};
                owed_count = 2'd1;
            end
            8'b1110????: begin
                held_point = {17'd0, b[3:0]};
                owed_count = 2'd2;
            end
            8'b11110???: begin
                held_point = {18'd0, b[2:0]};
                owed_count = 2'd3;
            end
            default: begin
                emit_point(REPLACEMENT_CP, 1'b1);
            end
        endcase
        // text ends straight after a lead byte
        if (owed_count != 2'd0 && end_flag) begin
            emit_point(REPLACEMENT_CP, 1'b1);
            drop_sequence();
        end
    endtask

    // work out the results of one accepted text byte
    task automatic decode_text_byte(input logic [7:0] b, input logic end_flag);
        byte_points.delete();
        if (owed_count == 2'd0) begin
            take_lead_byte(b, end_flag);
        end else if (b[7:6] == 2'b10) begin
            held_point = {held_point[CP_W-7:0], b[5:0]};
            owed_count = owed_count - 2'd1;
            if (owed_count == 2'd0) begin
                emit_point(held_point, 1'b0);
                held_point = '0;
            end else if (end_flag) begin
                emit_point(REPLACEMENT_CP, 1'b1);
                drop_sequence();
            end
        end else begin
            // broken sequence, then the byte starts afresh
            emit_point(REPLACEMENT_CP, 1'b1);
            drop_sequence();
            take_lead_byte(b, end_flag);
        end
        if (end_flag) drop_sequence();
        foreach (byte_points[k]) begin
            if (k == byte_points.size() - 1) begin
                byte_points[k].run_last    = 1'b1;
                byte_points[k].final_point = end_flag;
            end
            expected_points = {expected_points, byte_points[k]};
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic end_flag);
        text_item_t item;
        item.text_byte = b;
        item.text_end  = end_flag;
        item.hold      = (text_bytes.size() == directed_count)
                      || (text_bytes.size() == PAUSE_AT);
        text_bytes = {text_bytes, item};
    endtask

    // ---------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------

    logic       offer_live = 1'b0;
    int         gap_left = 0;
    logic       sender_steady = 1'b0;
    text_item_t next_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            offer_live = 1'b0;
            gap_left   = 0;
            s_tvalid  <= 1'b0;
        end else begin
            // predict on acceptance
            if (s_tvalid && s_tready) begin
                decode_text_byte(s_tdata, s_tlast);
                offer_live = 1'b0;
            end
            // load the next byte after its gap
            if (!offer_live) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (text_bytes.size() > 0
                             && !(text_bytes[0].hold && expected_points.size() > 0)) begin
                    next_item  = text_bytes.pop_front();
                    s_tdata   <= next_item.text_byte;
                    s_tlast   <= next_item.text_end;
                    offer_live = 1'b1;
                    if ($urandom_range(0, 31) == 0) sender_steady = !sender_steady;
                    gap_left = sender_steady ? 0 : $urandom_range(0, 11);
                end
            end
            s_tvalid <= offer_live;
        end
    end

    // ---------------------------------------------------------------
    // result monitor and checker
    // ---------------------------------------------------------------

    int     stall_left = 0;
    int     hold_left = 0;
    logic   hold_done = 1'b0;
    logic   receiver_steady = 1'b0;
    int     points_seen = 0;
    point_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                points_seen++;
                if (expected_points.size() == 0) begin
                    $error("unexpected result: code_point %h", m_tdata[CP_W-1:0]);
                    error_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.code_point) begin
                        $error("code_point: expected %h, got %h",
                               want.code_point, m_tdata[CP_W-1:0]);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.malformed) begin
                        $error("malformed: expected %b, got %b", want.malformed, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tuser[1]);
                        error_count++;
                    end
                    if (m_tlast !== want.final_point) begin
                        $error("final_point: expected %b, got %b",
                               want.final_point, m_tlast);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0) receiver_steady = !receiver_steady;
                stall_left = receiver_steady ? 0 : $urandom_range(0, 11);
                // one long back-pressure stretch to fill the block
                if (points_seen == HOLD_AT_POINT && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog on cycles without any handshake
    // ---------------------------------------------------------------

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("utf8_stream_decoder_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // sequence: stimulus, reset, drain, verdict
    // ---------------------------------------------------------------

    int   pick;
    int   seq_len;
    int   conts;
    logic [7:0] lead;

    initial begin
        directed_count = 24;
        // ascii extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        // two- and three-byte forms
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        // invalid start bytes
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        // sequence broken by ascii at end of text: two results
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b1);
        // sequence broken by a new lead byte
        add_byte(8'hC3, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b0);
        // premature end inside a four-byte form
        add_byte(8'hF0, 1'b0);
        add_byte(8'h90, 1'b1);
        // text ending on a lead byte
        add_byte(8'hE0, 1'b1);
        // broken sequence whose new lead byte also ends the text
        add_byte(8'hC2, 1'b0);
        add_byte(8'hE0, 1'b1);
        // largest four-byte value
        add_byte(8'hF7, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // plain ascii ending the text
        add_byte(8'h41, 1'b1);

        // random: mostly well-formed characters, some noise and cut sequences
        while (text_bytes.size() < directed_count + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
            end else begin
                seq_len = $urandom_range(1, 4);
                case (seq_len)
                    1: lead = 8'($urandom_range(0, 127));
                    2: lead = 8'hC0 | 8'($urandom_range(0, 31));
                    3: lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                conts = seq_len - 1;
                if (pick >= 88 && conts > 0) conts = $urandom_range(0, conts - 1);
                add_byte(lead, $urandom_range(0, 24) == 0);
                repeat (conts) add_byte(8'h80 | 8'($urandom_range(0, 63)),
                                        $urandom_range(0, 24) == 0);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // settle between edges before judging the drain
        @(negedge aclk);
        while (text_bytes.size() > 0 || offer_live || expected_points.size() > 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_points.size() != 0) begin
            $error("%0d results never arrived", expected_points.size());
            error_count++;
        end
        if (error_count == 0)
            $display("utf8_stream_decoder_test: done, clean");
        else
            $display("utf8_stream_decoder_test: done, errors");
        $finish;
    end

endmodule
